// File: rtl/lef_pkg.sv
// Package: shared types and constants for the 3x3 Laplacian edge filter.
package lef_pkg;

  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned COORD_W       = 10;
  localparam int unsigned CFG_DATA_W    = 11;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned DIM_MIN       = 3;
  localparam int unsigned WIDTH_RESET   = 600;
  localparam int unsigned HEIGHT_RESET  = 400;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned NB_SIZE       = 9;
  localparam int unsigned NB_CENTER     = 4;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } lef_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               run_last;
  } lef_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // Which results a pixel causes, in emission order mid, right, bottom.
  typedef struct packed {
    logic mid;     // delayed pixel one row and one column back
    logic filt;    // delayed pixel is interior and gets filtered
    logic right;   // right border pixel of the previous row
    logic bottom;  // bottom border pixel at the current column
  } lef_flags_t;

  // One classified pixel; nb index is column*3 + row, column 0 = c-2, row 0 = r-2.
  typedef struct packed {
    pix_t [NB_SIZE-1:0] nb;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    lef_flags_t         flags;
  } lef_job_t;

  typedef struct packed {
    logic busy;       // an item is held in the front stage
    logic at_origin;  // next input lands at column 0, row 0
  } lef_front_sts_t;

endpackage

// File: rtl/lef_front.sv
// Front end: frame counters, line stores, window and result classification.
module lef_front #(
  parameter int unsigned MAX_WIDTH  = lef_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lef_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lef_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lef_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lef_pkg::lef_in_t                  in_data_i,
  output lef_pkg::lef_job_t                 job_o,
  output logic                              job_valid_o,
  input  logic                              job_ready_i,
  output lef_pkg::lef_front_sts_t           sts_o
);
  import lef_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned DW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DHW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EXT_W = CFG_DATA_W + 2;
  localparam int unsigned W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int unsigned H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  logic [DW-1:0]  width_q, width_d;
  logic [DHW-1:0] height_q, height_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic           cfg_hit_w, cfg_hit_h, cfg_restart;
  logic [EXT_W-1:0] cfg_ext;

  logic           in_acc, s1_retire, has_res;
  logic           c_last, r_last;
  logic [DW-1:0]  w_m1;
  logic [DHW-1:0] h_m1;
  lef_flags_t     flags_now;

  logic               s1_valid_q;
  pix_t               s1_pix_q;
  logic [CW-1:0]      s1_addr_q;
  logic [COORD_W-1:0] s1_row_q;
  lef_flags_t         s1_flags_q;
  pix_t               old_rd_q, new_rd_q;
  pix_t               win_q [6];

  pix_t older_mem [MAX_WIDTH];
  pix_t newer_mem [MAX_WIDTH];

  // Configuration: saturate to 3..MAX and restart the frame.
  assign cfg_hit_w   = cfg_we_i && (cfg_idx_i == REG_FRAME_WIDTH);
  assign cfg_hit_h   = cfg_we_i && (cfg_idx_i == REG_FRAME_HEIGHT);
  assign cfg_restart = cfg_hit_w || cfg_hit_h;
  assign cfg_ext     = {2'b00, cfg_wdata_i};

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_hit_w) begin
      if (cfg_wdata_i < CFG_DATA_W'(DIM_MIN)) width_d = DW'(DIM_MIN);
      else if (cfg_ext > EXT_W'(MAX_WIDTH)) width_d = DW'(MAX_WIDTH);
      else width_d = DW'(cfg_wdata_i);
    end
    if (cfg_hit_h) begin
      if (cfg_wdata_i < CFG_DATA_W'(DIM_MIN)) height_d = DHW'(DIM_MIN);
      else if (cfg_ext > EXT_W'(MAX_HEIGHT)) height_d = DHW'(MAX_HEIGHT);
      else height_d = DHW'(cfg_wdata_i);
    end
  end

  // Handshake: the front stage holds one pixel until its job, if any, is taken.
  assign has_res    = s1_flags_q.mid || s1_flags_q.right || s1_flags_q.bottom;
  assign s1_retire  = s1_valid_q && (job_ready_i || !has_res);
  assign in_stall_o = s1_valid_q && !s1_retire;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign w_m1   = width_q - DW'(1);
  assign h_m1   = height_q - DHW'(1);
  assign c_last = (DW'(col_q) == w_m1);
  assign r_last = (DHW'(row_q) == h_m1);

  always_comb begin
    flags_now.mid    = (col_q != '0) && (row_q != '0);
    flags_now.filt   = (col_q > CW'(1)) && (row_q > RW'(1));
    flags_now.right  = c_last && (row_q != '0);
    flags_now.bottom = r_last;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (c_last) begin
        col_d = '0;
        row_d = r_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= DW'(W_RST);
      height_q   <= DHW'(H_RST);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      if (in_acc) s1_valid_q <= 1'b1;
      else if (s1_retire) s1_valid_q <= 1'b0;
      if (cfg_restart) begin
        for (int i = 0; i < 6; i++) win_q[i] <= '0;
      end else if (s1_retire) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= old_rd_q;
        win_q[4] <= new_rd_q;
        win_q[5] <= s1_pix_q;
      end
    end
  end

  // Payload of the front stage.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= pix_t'(in_data_i);
      s1_addr_q  <= col_q;
      s1_row_q   <= COORD_W'(row_q);
      s1_flags_q <= flags_now;
    end
  end

  // Line stores: read on accept, shift the column down one row on retire.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      old_rd_q <= older_mem[col_q];
      new_rd_q <= newer_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_retire) begin
      older_mem[s1_addr_q] <= new_rd_q;
      newer_mem[s1_addr_q] <= s1_pix_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) job_o.nb[i] = win_q[i];
    job_o.nb[6] = old_rd_q;
    job_o.nb[7] = new_rd_q;
    job_o.nb[8] = s1_pix_q;
    job_o.col   = COORD_W'(s1_addr_q);
    job_o.row   = s1_row_q;
    job_o.flags = s1_flags_q;
  end

  assign job_valid_o     = s1_valid_q && has_res;
  assign sts_o.busy      = s1_valid_q;
  assign sts_o.at_origin = (col_q == '0) && (row_q == '0);

endmodule

// File: rtl/lef_queue.sv
// Short job queue between the front and back ends.
module lef_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  lef_pkg::lef_job_t           push_data_i,
  output logic                        ready_o,
  output logic                        valid_o,
  output lef_pkg::lef_job_t           data_o,
  input  logic                        pop_i,
  output logic [lef_pkg::QCNT_W-1:0]  level_o
);
  import lef_pkg::*;

  lef_job_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = entry_q[rd_ptr_q];
  assign level_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (do_push && !do_pop) count_q <= count_q + QCNT_W'(1);
      else if (do_pop && !do_push) count_q <= count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/lef_back.sv
// Back end: neighbor sums, clamp, and emission of up to three results per job.
module lef_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  lef_pkg::lef_job_t   job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lef_pkg::lef_out_t   out_data_o
);
  import lef_pkg::*;

  localparam int unsigned SUM_W  = CHAN_W + 3;
  localparam int unsigned DIFF_W = CHAN_W + 4;

  // Clamp 8*center - neighbor sum to 0..255.
  function automatic logic [CHAN_W-1:0] lap_clamp(input logic [CHAN_W-1:0] ctr,
                                                  input logic [SUM_W-1:0]  nsum);
    logic signed [DIFF_W-1:0] diff;
    logic [CHAN_W-1:0]        res;
    diff = $signed({1'b0, ctr, 3'b000}) - $signed({1'b0, nsum});
    if (diff[DIFF_W-1]) res = '0;
    else if (diff > DIFF_W'(255)) res = '1;
    else res = diff[CHAN_W-1:0];
    return res;
  endfunction

  logic [SUM_W-1:0]   nsum_now [3];
  logic               x_valid_q;
  pix_t               x_ctr_q;
  logic [SUM_W-1:0]   x_nsum_q [3];
  logic [COORD_W-1:0] x_col_q, x_row_q;
  lef_flags_t         x_flags_q;

  logic               y_valid_q;
  pix_t               y_pix_q, y_pix_d;
  logic [COORD_W-1:0] y_col_q, y_row_q;
  logic [2:0]         y_pend_q, y_rest, y_sel;

  logic     out_valid_q, out_ready, emit, y_done, y_free, x_adv, x_free;
  lef_out_t out_q, out_d;

  // Neighbor sums per channel; channel k sits at bits 8k+7:8k.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nsum_now[k] = '0;
      for (int i = 0; i < NB_SIZE; i++) begin
        if (i != NB_CENTER) nsum_now[k] = nsum_now[k] + SUM_W'(job_i.nb[i][CHAN_W*k +: CHAN_W]);
      end
    end
  end

  always_comb begin
    y_pix_d.blue  = lap_clamp(x_ctr_q.blue,  x_nsum_q[0]);
    y_pix_d.green = lap_clamp(x_ctr_q.green, x_nsum_q[1]);
    y_pix_d.red   = lap_clamp(x_ctr_q.red,   x_nsum_q[2]);
    if (!x_flags_q.filt) y_pix_d = '0;
  end

  // Pick the earliest pending result: mid, then right, then bottom.
  always_comb begin
    if (y_pend_q[0]) y_sel = 3'b001;
    else if (y_pend_q[1]) y_sel = 3'b010;
    else y_sel = 3'b100;
    y_rest = y_pend_q & ~y_sel;
  end

  assign out_ready = !out_valid_q || !out_stall_i;
  assign emit      = y_valid_q && out_ready;
  assign y_done    = emit && (y_rest == '0);
  assign y_free    = !y_valid_q || y_done;
  assign x_adv     = x_valid_q && y_free;
  assign x_free    = !x_valid_q || x_adv;
  assign job_pop_o = job_valid_i && x_free;

  always_comb begin
    out_d.red_out   = '0;
    out_d.green_out = '0;
    out_d.blue_out  = '0;
    out_d.out_col   = y_col_q;
    out_d.out_row   = y_row_q;
    out_d.run_last  = (y_rest == '0);
    if (y_sel[0]) begin
      out_d.red_out   = y_pix_q.red;
      out_d.green_out = y_pix_q.green;
      out_d.blue_out  = y_pix_q.blue;
      out_d.out_col   = y_col_q - COORD_W'(1);
      out_d.out_row   = y_row_q - COORD_W'(1);
    end else if (y_sel[1]) begin
      out_d.out_row   = y_row_q - COORD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q   <= 1'b0;
      y_valid_q   <= 1'b0;
      y_pend_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) x_valid_q <= 1'b1;
      else if (x_adv) x_valid_q <= 1'b0;
      if (x_adv) begin
        y_valid_q <= 1'b1;
        y_pend_q  <= {x_flags_q.bottom, x_flags_q.right, x_flags_q.mid};
      end else if (emit) begin
        y_valid_q <= !y_done;
        y_pend_q  <= y_rest;
      end
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      x_ctr_q   <= job_i.nb[NB_CENTER];
      x_col_q   <= job_i.col;
      x_row_q   <= job_i.row;
      x_flags_q <= job_i.flags;
      for (int k = 0; k < 3; k++) x_nsum_q[k] <= nsum_now[k];
    end
    if (x_adv) begin
      y_pix_q <= y_pix_d;
      y_col_q <= x_col_q;
      y_row_q <= x_row_q;
    end
    if (emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/laplacian_edge_filter_3x3_top.sv
// Top level of the streaming 3x3 Laplacian edge filter on RGB pixels.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_stall    lef_in_t  (one raster pixel)
//  out      output     out_valid/out_stall  lef_out_t (one result pixel)
//  cfg      input      cfg_we               cfg_idx, cfg_wdata (write only)
//
// One pixel transfer per clock is sustained while each pixel yields at most
// one result and out_stall is low. A pixel that yields two or three results
// holds the back end until all are out. The four-entry job queue absorbs an
// occasional one, as at a row end. On the bottom row every pixel but the first
// yields two or three, so in_stall slows the input there. A pixel's first
// result passes the front stage, queue, x and y stages and output register.
// Reset clears counters, window and handshake state, not the line stores,
// which need no clearing. An output stall backs up via the queue to in_stall.
module laplacian_edge_filter_3x3_top #(
  parameter int unsigned MAX_WIDTH  = lef_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lef_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lef_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lef_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lef_pkg::lef_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lef_pkg::lef_out_t              out_data_o
);
  import lef_pkg::*;

  lef_job_t          fr_job, q_job;
  logic              fr_job_valid, q_ready, q_valid, q_pop;
  logic [QCNT_W-1:0] q_level;
  lef_front_sts_t    fr_sts;

  // Front: count position, read and update line stores, classify results.
  lef_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_o       (fr_job),
    .job_valid_o (fr_job_valid),
    .job_ready_i (q_ready),
    .sts_o       (fr_sts)
  );

  // Queue: decouple pixel intake from result emission.
  lef_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_job_valid),
    .push_data_i (fr_job),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .data_o      (q_job),
    .pop_i       (q_pop),
    .level_o     (q_level)
  );

  // Back: filter and drain each job's results in order.
  lef_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A register write restarts the frame at the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> fr_sts.at_origin)
    else $error("frame did not restart after register write");

  // Results of one pixel leave back to back: a non-final result is followed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.run_last) |=> out_valid_o)
    else $error("gap inside a pixel's result run");

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue overflow");

  // Input stalls only while the front stage holds a pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> fr_sts.busy)
    else $error("input stalled with empty front stage");

endmodule
